>>> design/ftva_pkg.sv
// ----------------------------------------------------------------------------
// ftva_pkg
// shared types and constants of the feedforward thrust vector angle core
// ----------------------------------------------------------------------------
`default_nettype none

package ftva_pkg;

  // register stages inside one axis unit
  localparam int unsigned AXIS_ST = 24;

  // cordic iterations
  localparam int unsigned CORDIC_N = 17;

  // pi/2 in q4.12
  localparam logic [12:0] HALF_PI_Q12 = 13'd6434;

  // per-axis operands handed from the shared front end
  typedef struct packed {
    logic [45:0]        tsq;
    logic [33:0]        tw_mag;
    logic               tw_neg;
    logic signed [16:0] err;
  } ax_in_t;

  // per-axis result
  typedef struct packed {
    logic signed [15:0] angle;
    logic               sat;
  } ax_out_t;

  // atan(2^-i) in q16
  function automatic logic [15:0] atan_q16(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30386;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/feedforward_thrust_vector_angle_core.sv
// throughput: one word per cycle; a two-entry output register with skid keeps taking
//   input while a finished result waits, the pipeline freezes only when the skid fills
// config products (l*l*m, 6*b*t) settle through registers after a register write
// reset: asynchronous, active low; clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
// feedforward_thrust_vector_angle_core
// feed-forward gimbal angles for yaw and pitch from one control sample
// ----------------------------------------------------------------------------
`default_nettype none

module feedforward_thrust_vector_angle_core
  import ftva_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] velocity_i,
  input  logic signed [15:0] yaw_measured_i,
  input  logic signed [15:0] yaw_target_i,
  input  logic signed [19:0] yaw_rate_i,
  input  logic signed [15:0] pitch_measured_i,
  input  logic signed [15:0] pitch_target_i,
  input  logic signed [19:0] pitch_rate_i,
  input  logic [31:0]        thrust_in_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] yaw_gimbal_o,
  output logic signed [15:0] pitch_gimbal_o,
  output logic [31:0]        thrust_out_o,
  output logic               speed_zero_o,
  output logic               yaw_arg_saturated_o,
  output logic               pitch_arg_saturated_o
);

  // register indexes
  localparam logic [2:0] CFG_MASS  = 3'd0;
  localparam logic [2:0] CFG_THR   = 3'd1;
  localparam logic [2:0] CFG_GARM  = 3'd2;
  localparam logic [2:0] CFG_UARM  = 3'd3;
  localparam logic [2:0] CFG_LOOK  = 3'd4;
  localparam logic [2:0] CFG_LIMIT = 3'd5;

  // stage plan: input register, 8 divide stages, product stage, then the axis units
  localparam int unsigned DIV_ST   = 8;
  localparam int unsigned FRONT_ST = DIV_ST + 2;
  localparam int unsigned NST      = FRONT_ST + AXIS_ST;

  typedef struct packed {
    logic               vneg;
    logic signed [16:0] err_y;
    logic signed [16:0] err_p;
    logic [19:0]        wmag_y;
    logic [19:0]        wmag_p;
    logic               wneg_y;
    logic               wneg_p;
  } front_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [30:0] quo;
    logic [31:0] vmag;
    logic        tsat;
  } tdiv_t;

  typedef struct packed {
    logic [31:0] thrust;
    logic        vzero;
  } side_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [31:0]        thrust;
    logic               vzero;
    logic               ys;
    logic               ps;
  } res_t;

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [31:0] mass_q, full_thrust_q, gimbal_arm_q, upper_arm_q, lookahead_q;
  logic [12:0] angle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q        <= 32'd65536;
      full_thrust_q <= 32'd65536;
      gimbal_arm_q  <= 32'd65536;
      upper_arm_q   <= 32'd65536;
      lookahead_q   <= 32'd65536;
      angle_limit_q <= 13'd715;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASS:  mass_q        <= cfg_wdata_i;
        CFG_THR:   full_thrust_q <= cfg_wdata_i;
        CFG_GARM:  gimbal_arm_q  <= cfg_wdata_i;
        CFG_UARM:  upper_arm_q   <= cfg_wdata_i;
        CFG_LOOK:  lookahead_q   <= cfg_wdata_i;
        CFG_LIMIT: angle_limit_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // config products, free running; the user must change them only while the block is
  // idle (not enforced); an item needs them no earlier than its eleventh stage
  // --------------------------------------------------------------------------
  logic [32:0] len_q;    // l = ag + b
  logic [63:0] bt_q;     // b * t
  logic [65:0] lsq_q;    // l * l
  logic [66:0] bt6_q;    // 6 * b * t
  logic [63:0] pm_lo_q;  // low 32 bits of (l*l >> 16), times m
  logic [49:0] pm_hi_q;  // high 18 bits of (l*l >> 16), times m
  logic [81:0] l2m_q;

  always_ff @(posedge clk_i) begin
    len_q   <= {1'b0, upper_arm_q} + {1'b0, gimbal_arm_q};
    bt_q    <= 64'(gimbal_arm_q) * 64'(full_thrust_q);
    lsq_q   <= 66'(len_q) * 66'(len_q);
    bt6_q   <= 67'({bt_q, 2'b0}) + 67'({bt_q, 1'b0});
    pm_lo_q <= 64'(lsq_q[47:16]) * 64'(mass_q);
    pm_hi_q <= 50'(lsq_q[65:48]) * 50'(mass_q);
    l2m_q   <= {pm_hi_q, 32'b0} + 82'(pm_lo_q);
  end

  // --------------------------------------------------------------------------
  // flow control: the whole pipeline moves together unless the skid is full
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_valid_q, out_valid_q;
  logic [NST-1:0] vld_q;

  assign adv        = !skid_valid_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // side data that rides along the whole pipeline
  side_t side_q [NST];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].thrust <= thrust_in_i;
      side_q[0].vzero  <= (velocity_i == '0);
      for (int k = 1; k < NST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: magnitudes, angle errors and divide setup for t = d / |v|
  // --------------------------------------------------------------------------
  front_t front_q [DIV_ST+1];
  tdiv_t  div_q   [DIV_ST+1];
  front_t front_d;
  tdiv_t  div_init;

  always_comb begin
    front_d.vneg   = velocity_i[31];
    front_d.err_y  = {yaw_target_i[15], yaw_target_i} - {yaw_measured_i[15], yaw_measured_i};
    front_d.err_p  = {pitch_target_i[15], pitch_target_i}
                   - {pitch_measured_i[15], pitch_measured_i};
    front_d.wneg_y = yaw_rate_i[19];
    front_d.wneg_p = pitch_rate_i[19];
    // two's complement negate also covers the most negative rate
    front_d.wmag_y = yaw_rate_i[19] ? (20'd0 - yaw_rate_i) : yaw_rate_i;
    front_d.wmag_p = pitch_rate_i[19] ? (20'd0 - pitch_rate_i) : pitch_rate_i;

    div_init.vmag  = velocity_i[31] ? (32'd0 - velocity_i) : velocity_i;
    // quotient reaches 2^31 exactly when d >= |v| * 2^15
    div_init.tsat  = {15'b0, lookahead_q[31:15]} >= div_init.vmag;
    div_init.rem   = {lookahead_q, 16'b0};
    div_init.quo   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q[0] <= front_d;
      div_q[0]   <= div_init;
    end
  end

  // --------------------------------------------------------------------------
  // stages 1..8: restoring divide, four quotient bits per stage (bit 30 down)
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_ST; g++) begin : g_tdiv
    tdiv_t div_d;
    always_comb begin
      int          b;
      logic [62:0] sh;
      div_d = div_q[g];
      for (int j = 0; j < 4; j++) begin
        b  = 30 - 4*g - j;
        sh = '0;
        if (b >= 0) begin
          sh = 63'(div_d.vmag) << b;
          if ({15'b0, div_d.rem} >= sh) begin
            div_d.rem    = div_d.rem - sh[47:0];
            div_d.quo[b] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[g+1]   <= div_d;
        front_q[g+1] <= front_q[g];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: t squared and t * rate for both axes
  // --------------------------------------------------------------------------
  ax_in_t ax_y_q, ax_p_q;
  logic [30:0] tmag;
  logic [61:0] tsq_w;
  logic [50:0] twy_w, twp_w;

  // long lookahead times saturate at 2^31 - 1
  assign tmag  = div_q[DIV_ST].tsat ? 31'h7FFF_FFFF : div_q[DIV_ST].quo;
  assign tsq_w = 62'(tmag) * 62'(tmag);
  assign twy_w = 51'(tmag) * 51'(front_q[DIV_ST].wmag_y);
  assign twp_w = 51'(tmag) * 51'(front_q[DIV_ST].wmag_p);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_y_q.tsq    <= tsq_w[61:16];
      ax_y_q.tw_mag <= twy_w[49:16];
      ax_y_q.tw_neg <= front_q[DIV_ST].vneg != front_q[DIV_ST].wneg_y;
      ax_y_q.err    <= front_q[DIV_ST].err_y;
      ax_p_q.tsq    <= tsq_w[61:16];
      ax_p_q.tw_mag <= twp_w[49:16];
      ax_p_q.tw_neg <= front_q[DIV_ST].vneg != front_q[DIV_ST].wneg_p;
      ax_p_q.err    <= front_q[DIV_ST].err_p;
    end
  end

  // --------------------------------------------------------------------------
  // stages 10..33: one axis unit each for yaw and pitch
  // --------------------------------------------------------------------------
  ax_out_t yaw_res, pitch_res;

  ftva_axis u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .ax_i  (ax_y_q),
    .l2m_i (l2m_q),
    .bt6_i (bt6_q),
    .lim_i (angle_limit_q),
    .ax_o  (yaw_res)
  );

  ftva_axis u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .ax_i  (ax_p_q),
    .l2m_i (l2m_q),
    .bt6_i (bt6_q),
    .lim_i (angle_limit_q),
    .ax_o  (pitch_res)
  );

  // zero speed forces both angles and flags to zero
  res_t res_new;

  always_comb begin
    res_new.vzero  = side_q[NST-1].vzero;
    res_new.thrust = side_q[NST-1].thrust;
    res_new.yaw    = side_q[NST-1].vzero ? 16'sd0 : yaw_res.angle;
    res_new.pitch  = side_q[NST-1].vzero ? 16'sd0 : pitch_res.angle;
    res_new.ys     = !side_q[NST-1].vzero && yaw_res.sat;
    res_new.ps     = !side_q[NST-1].vzero && pitch_res.sat;
  end

  // --------------------------------------------------------------------------
  // output register with skid
  // --------------------------------------------------------------------------
  logic push;
  logic out_free;
  res_t out_q, skid_q;

  assign push     = adv && vld_q[NST-1];
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign yaw_gimbal_o          = out_q.yaw;
  assign pitch_gimbal_o        = out_q.pitch;
  assign thrust_out_o          = out_q.thrust;
  assign speed_zero_o          = out_q.vzero;
  assign yaw_arg_saturated_o   = out_q.ys;
  assign pitch_arg_saturated_o = out_q.ps;

`ifndef ASSERT_OFF
  // a word only sits in the skid behind a word in the output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  // zero speed word carries zero angles and no flags
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && speed_zero_o) |->
      (yaw_gimbal_o == 16'sd0 && pitch_gimbal_o == 16'sd0 &&
       !yaw_arg_saturated_o && !pitch_arg_saturated_o))
    else $error("zero speed word with nonzero angle or flag");

  // yaw angle stays inside the configured clamp
  a_yaw_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_gimbal_o <= $signed({3'b0, angle_limit_q}) &&
                     yaw_gimbal_o >= -$signed({3'b0, angle_limit_q})))
    else $error("yaw angle outside clamp");

  // a saturated argument gives a nonzero angle unless the clamp is zero
  a_yaw_sat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && yaw_arg_saturated_o && angle_limit_q != '0) |->
      yaw_gimbal_o != 16'sd0)
    else $error("saturated yaw argument with zero angle");
`endif

endmodule

`default_nettype wire

>>> design/ftva_axis.sv
// ----------------------------------------------------------------------------
// ftva_axis
// one axis: error term, wide products, asin argument divide, isqrt and cordic
// ----------------------------------------------------------------------------
`default_nettype none

module ftva_axis
  import ftva_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  ax_in_t      ax_i,
  input  logic [81:0] l2m_i,
  input  logic [66:0] bt6_i,
  input  logic [12:0] lim_i,
  output ax_out_t     ax_o
);

  localparam int unsigned QDIV_ST = 8;
  localparam int unsigned ROOT_ST = 4;
  localparam int unsigned CR_ST   = 6;

  typedef struct packed {
    logic n_neg;
    logic zero;
    logic sat;
  } flg_t;

  typedef struct packed {
    logic [127:0] rem;
    logic [112:0] den;
    logic [15:0]  q;
    flg_t         f;
  } qdiv_t;

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] res;
    logic [15:0] q;
    flg_t        f;
  } root_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [19:0] z;
    flg_t               f;
  } rot_t;

  // stage 0: n = err - t*w
  logic [34:0] n_mag_d, n_mag_q;
  logic        n_neg_d, n_neg_q;
  logic [45:0] tsq_q;

  always_comb begin
    logic [35:0] tw_s;
    logic [35:0] n_s;
    logic [35:0] n_abs;
    tw_s    = ax_i.tw_neg ? (36'd0 - {2'b0, ax_i.tw_mag}) : {2'b0, ax_i.tw_mag};
    n_s     = {{19{ax_i.err[16]}}, ax_i.err} - tw_s;
    n_neg_d = n_s[35];
    n_abs   = n_s[35] ? (36'd0 - n_s) : n_s;
    n_mag_d = n_abs[34:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_mag_q <= n_mag_d;
      n_neg_q <= n_neg_d;
      tsq_q   <= ax_i.tsq;
    end
  end

  // stage 1: partial products
  logic [83:0] l2m_x;
  logic [68:0] bt6_x;
  logic [62:0] pn_q [3];
  logic [68:0] pd_q [3];
  logic        n_neg1_q;

  assign l2m_x = {2'b0, l2m_i};
  assign bt6_x = {2'b0, bt6_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pn_q[k] <= 63'(l2m_x[28*k +: 28]) * 63'(n_mag_q);
        pd_q[k] <= 69'(bt6_x[23*k +: 23]) * 69'(tsq_q);
      end
      n_neg1_q <= n_neg_q;
    end
  end

  // stage 2: sum into numerator and denominator
  logic [116:0] num_q;
  logic [112:0] den_q;
  logic         n_neg2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q    <= 117'(pn_q[0]) + (117'(pn_q[1]) << 28) + (117'(pn_q[2]) << 56);
      den_q    <= 113'(pd_q[0]) + (113'(pd_q[1]) << 23) + (113'(pd_q[2]) << 46);
      n_neg2_q <= n_neg1_q;
    end
  end

  // stage 3: special cases, divide setup
  qdiv_t qd_q [QDIV_ST+1];
  qdiv_t qd_init;

  always_comb begin
    qd_init.f.n_neg = n_neg2_q;
    qd_init.f.zero  = (num_q == '0);
    qd_init.f.sat   = (num_q != '0) && ({num_q, 4'b0} > {8'b0, den_q});
    qd_init.rem     = 128'({num_q, 19'b0});
    qd_init.den     = den_q;
    qd_init.q       = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qd_q[0] <= qd_init;
    end
  end

  // stages 4..11: restoring divide, two quotient bits per stage
  for (genvar g = 0; g < QDIV_ST; g++) begin : g_qdiv
    qdiv_t qd_d;
    always_comb begin
      int          b;
      logic [127:0] sh;
      qd_d = qd_q[g];
      for (int j = 0; j < 2; j++) begin
        b  = 15 - 2*g - j;
        sh = {15'b0, qd_d.den} << b;
        if (qd_d.rem >= sh) begin
          qd_d.rem  = qd_d.rem - sh;
          qd_d.q[b] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[g+1] <= qd_d;
      end
    end
  end

  // stage 12: radicand 1 - q^2
  root_t rt_q [ROOT_ST+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_q[0].n   <= 32'h4000_0000 - (32'(qd_q[QDIV_ST].q) * 32'(qd_q[QDIV_ST].q));
      rt_q[0].res <= '0;
      rt_q[0].q   <= qd_q[QDIV_ST].q;
      rt_q[0].f   <= qd_q[QDIV_ST].f;
    end
  end

  // stages 13..16: integer square root, four iterations per stage
  for (genvar g = 0; g < ROOT_ST; g++) begin : g_root
    root_t rt_d;
    always_comb begin
      logic [31:0] bit_v;
      rt_d = rt_q[g];
      for (int j = 0; j < 4; j++) begin
        bit_v = 32'd1 << (30 - 2*(4*g + j));
        if (rt_d.n >= rt_d.res + bit_v) begin
          rt_d.n   = rt_d.n - (rt_d.res + bit_v);
          rt_d.res = (rt_d.res >> 1) + bit_v;
        end else begin
          rt_d.res = rt_d.res >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[g+1] <= rt_d;
      end
    end
  end

  // stages 17..22: cordic vectoring, three iterations per stage, two in the last
  rot_t cr_q [CR_ST];
  rot_t cr_init;

  always_comb begin
    cr_init.x = $signed({4'b0, rt_q[ROOT_ST].res[15:0], 14'b0});
    cr_init.y = $signed({4'b0, rt_q[ROOT_ST].q, 14'b0});
    cr_init.z = '0;
    cr_init.f = rt_q[ROOT_ST].f;
  end

  for (genvar g = 0; g < CR_ST; g++) begin : g_cordic
    rot_t cr_cur;
    rot_t cr_d;
    if (g == 0) begin : g_first
      assign cr_cur = cr_init;
    end else begin : g_next
      assign cr_cur = cr_q[g-1];
    end
    always_comb begin
      int                 i;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [19:0] at;
      cr_d = cr_cur;
      for (int j = 0; j < 3; j++) begin
        i = 3*g + j;
        if (i < CORDIC_N) begin
          dx = cr_d.y >>> i;
          dy = cr_d.x >>> i;
          at = $signed({4'b0, atan_q16(5'(i))});
          if (cr_d.y > 0) begin
            cr_d.x = cr_d.x + dx;
            cr_d.y = cr_d.y - dy;
            cr_d.z = cr_d.z + at;
          end else begin
            cr_d.x = cr_d.x - dx;
            cr_d.y = cr_d.y + dy;
            cr_d.z = cr_d.z - at;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cr_q[g] <= cr_d;
      end
    end
  end

  // stage 23: round, special cases, sign and clamp
  ax_out_t ax_d, ax_q;

  always_comb begin
    logic signed [19:0] zc;
    logic signed [19:0] zr;
    logic [12:0]        mag;
    logic signed [15:0] ang;
    logic signed [15:0] lim_s;
    zc  = (cr_q[CR_ST-1].z < 0) ? 20'sd0 : cr_q[CR_ST-1].z;
    zr  = (zc + 20'sd8) >>> 4;
    mag = (zr > $signed({7'b0, HALF_PI_Q12})) ? HALF_PI_Q12 : zr[12:0];
    if (cr_q[CR_ST-1].f.zero) begin
      mag = '0;
    end else if (cr_q[CR_ST-1].f.sat) begin
      mag = HALF_PI_Q12;
    end
    ang   = cr_q[CR_ST-1].f.n_neg ? -$signed({3'b0, mag}) : $signed({3'b0, mag});
    lim_s = $signed({3'b0, lim_i});
    if (ang > lim_s) begin
      ang = lim_s;
    end
    if (ang < -lim_s) begin
      ang = -lim_s;
    end
    ax_d.angle = ang;
    ax_d.sat   = cr_q[CR_ST-1].f.sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax_d;
    end
  end

  assign ax_o = ax_q;

endmodule

`default_nettype wire

>>> bench/feedforward_thrust_vector_angle_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedforward_thrust_vector_angle_core_tb
// self-checking bench: drives control samples through the valid/ready input,
// predicts both gimbal angles in integer arithmetic and checks every result word
// in order, over several register settings and idle patterns
// ----------------------------------------------------------------------------
`default_nettype none

module feedforward_thrust_vector_angle_core_tb;
  import ftva_pkg::*;

  // register indexes
  localparam logic [2:0] REG_MASS   = 3'd0;
  localparam logic [2:0] REG_THRUST = 3'd1;
  localparam logic [2:0] REG_GIMBAL = 3'd2;
  localparam logic [2:0] REG_UPPER  = 3'd3;
  localparam logic [2:0] REG_LOOK   = 3'd4;
  localparam logic [2:0] REG_LIMIT  = 3'd5;
  localparam logic [2:0] REG_NONE   = 3'd6;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned PHASE_ITEMS = 135;
  localparam longint      T_MAX       = 64'd2147483647;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic signed [15:0] yaw_meas;
    logic signed [15:0] yaw_targ;
    logic signed [19:0] yaw_rate;
    logic signed [15:0] pitch_meas;
    logic signed [15:0] pitch_targ;
    logic signed [19:0] pitch_rate;
    logic [31:0]        thrust;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [31:0]        thrust;
    logic               speed_zero;
    logic               yaw_sat;
    logic               pitch_sat;
  } gimbal_t;

  // --------------------------------------------------------------------------
  // gimbal angle predictor and ordered store of expected result words
  // --------------------------------------------------------------------------
  class gimbal_scoreboard;
    logic [31:0] mass, full_thrust, gimbal_arm, upper_arm, lookahead;
    logic [12:0] angle_limit;
    gimbal_t     pending_q[$];
    int          errors;

    function new();
      mass = 32'd65536; full_thrust = 32'd65536; gimbal_arm = 32'd65536;
      upper_arm = 32'd65536; lookahead = 32'd65536; angle_limit = 13'd715;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MASS:   mass = val;
        REG_THRUST: full_thrust = val;
        REG_GIMBAL: gimbal_arm = val;
        REG_UPPER:  upper_arm = val;
        REG_LOOK:   lookahead = val;
        REG_LIMIT:  angle_limit = val[12:0];
        default: ;
      endcase
    endfunction

    // asin of a q15 ratio by cordic vectoring, q4.12 out
    function longint asin_q12(logic [63:0] q);
      logic [63:0] n, res, bitv;
      longint x, y, z, dx, dy, r;
      n = 64'd1 << 30;
      n = n - q * q;
      res = 0;
      bitv = 64'd1 << 30;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      x = longint'(res << 14);
      y = longint'(q << 14);
      z = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + longint'(atan_q16(i[4:0]));
        end else begin
          x = x - dx; y = y + dy; z = z - longint'(atan_q16(i[4:0]));
        end
      end
      if (z < 0) z = 0;
      r = (z + 8) >>> 4;
      return (r > longint'(HALF_PI_Q12)) ? longint'(HALF_PI_Q12) : r;
    endfunction

    function void axis_angle(logic [63:0] vmag, bit vneg, logic signed [15:0] meas,
                             logic signed [15:0] targ, logic signed [19:0] rate,
                             output logic signed [15:0] ang, output logic sat);
      logic [63:0]  tmag, wmag, twmag, nmag, l2, tsq, q;
      logic [33:0]  len;
      logic [127:0] sq, num, den;
      longint       w, n, mag, lim, a;
      bit           twneg;
      tmag = ({32'b0, lookahead} << 16) / vmag;
      if (tmag > T_MAX) tmag = T_MAX;
      w = rate;
      wmag = (w < 0) ? -w : w;
      twmag = (tmag * wmag) >> 16;
      twneg = vneg != (w < 0);
      n = longint'(targ) - longint'(meas);
      n = n - (twneg ? -longint'(twmag) : longint'(twmag));
      nmag = (n < 0) ? -n : n;
      len = {2'b0, upper_arm} + {2'b0, gimbal_arm};
      sq = 128'(len) * 128'(len);
      l2 = 64'(sq >> 16);
      num = 128'(l2) * 128'(mass) * 128'(nmag);
      tsq = (tmag * tmag) >> 16;
      den = 128'(gimbal_arm) * 128'(full_thrust) * 128'd6 * 128'(tsq);
      sat = 1'b0;
      if (num == 0) begin
        mag = 0;
      end else if ((num << 4) > den) begin
        // asin argument beyond one
        sat = 1'b1;
        mag = longint'(HALF_PI_Q12);
      end else begin
        q = 64'((num << 19) / den);
        mag = asin_q12(q);
      end
      a = (n < 0) ? -mag : mag;
      lim = longint'(angle_limit);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      ang = a[15:0];
    endfunction

    function void note_sample(sample_t s);
      gimbal_t     g;
      logic [63:0] vmag;
      g = '0;
      g.thrust = s.thrust;
      if (s.velocity == 0) begin
        g.speed_zero = 1'b1;
      end else begin
        vmag = (s.velocity < 0) ? -longint'(s.velocity) : longint'(s.velocity);
        axis_angle(vmag, s.velocity < 0, s.yaw_meas, s.yaw_targ, s.yaw_rate,
                   g.yaw, g.yaw_sat);
        axis_angle(vmag, s.velocity < 0, s.pitch_meas, s.pitch_targ, s.pitch_rate,
                   g.pitch, g.pitch_sat);
      end
      pending_q.push_back(g);
    endfunction

    function void check_result(gimbal_t got);
      gimbal_t exp_g;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_g = pending_q.pop_front();
      if (got.yaw !== exp_g.yaw) begin
        $display("%0t: yaw_gimbal exp %0d got %0d", $time, exp_g.yaw, got.yaw);
        errors++;
      end
      if (got.pitch !== exp_g.pitch) begin
        $display("%0t: pitch_gimbal exp %0d got %0d", $time, exp_g.pitch, got.pitch);
        errors++;
      end
      if (got.thrust !== exp_g.thrust) begin
        $display("%0t: thrust_out exp %h got %h", $time, exp_g.thrust, got.thrust);
        errors++;
      end
      if (got.speed_zero !== exp_g.speed_zero) begin
        $display("%0t: speed_zero exp %b got %b", $time, exp_g.speed_zero,
                 got.speed_zero);
        errors++;
      end
      if (got.yaw_sat !== exp_g.yaw_sat) begin
        $display("%0t: yaw_arg_saturated exp %b got %b", $time, exp_g.yaw_sat,
                 got.yaw_sat);
        errors++;
      end
      if (got.pitch_sat !== exp_g.pitch_sat) begin
        $display("%0t: pitch_arg_saturated exp %b got %b", $time, exp_g.pitch_sat,
                 got.pitch_sat);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut signals
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] velocity_i;
  logic signed [15:0] yaw_measured_i, yaw_target_i, pitch_measured_i, pitch_target_i;
  logic signed [19:0] yaw_rate_i, pitch_rate_i;
  logic [31:0]        thrust_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] yaw_gimbal_o, pitch_gimbal_o;
  logic [31:0]        thrust_out_o;
  logic               speed_zero_o, yaw_arg_saturated_o, pitch_arg_saturated_o;

  feedforward_thrust_vector_angle_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .velocity_i, .yaw_measured_i, .yaw_target_i,
    .yaw_rate_i, .pitch_measured_i, .pitch_target_i, .pitch_rate_i, .thrust_in_i,
    .out_valid_o, .out_ready_i, .yaw_gimbal_o, .pitch_gimbal_o, .thrust_out_o,
    .speed_zero_o, .yaw_arg_saturated_o, .pitch_arg_saturated_o
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gimbal_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check on each accepted word, then pick the next ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i)
        sb.check_result({yaw_gimbal_o, pitch_gimbal_o, thrust_out_o, speed_zero_o,
                         yaw_arg_saturated_o, pitch_arg_saturated_o});
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // one word on the input channel, optional idle gap ahead of it
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    velocity_i       <= s.velocity;
    yaw_measured_i   <= s.yaw_meas;
    yaw_target_i     <= s.yaw_targ;
    yaw_rate_i       <= s.yaw_rate;
    pitch_measured_i <= s.pitch_meas;
    pitch_target_i   <= s.pitch_targ;
    pitch_rate_i     <= s.pitch_rate;
    thrust_in_i      <= s.thrust;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
  endtask

  // wait until every expected word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // write enable stays high across back to back writes
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(logic [31:0] m, logic [31:0] t, logic [31:0] b,
                           logic [31:0] ag, logic [31:0] d, logic [31:0] lim);
    write_reg(REG_MASS, m);
    write_reg(REG_THRUST, t);
    write_reg(REG_GIMBAL, b);
    write_reg(REG_UPPER, ag);
    write_reg(REG_LOOK, d);
    write_reg(REG_LIMIT, lim);
    // unused index must not disturb anything
    write_reg(REG_NONE + 3'($urandom_range(1)), $urandom);
    cfg_we_i <= 1'b0;
    // wait for the config products to settle after a write
    repeat (8) @(posedge clk_i);
  endtask

  function automatic sample_t make_sample(
      logic signed [31:0] v, logic signed [15:0] ym, logic signed [15:0] yt,
      logic signed [19:0] yr, logic signed [15:0] pm, logic signed [15:0] pt,
      logic signed [19:0] pr, logic [31:0] th);
    return '{v, ym, yt, yr, pm, pt, pr, th};
  endfunction

  // mostly physical samples so the asin path gets exercised, some pure noise
  function automatic sample_t rand_sample();
    sample_t s;
    s = sample_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(7) != 0) begin
      case ($urandom_range(9))
        0:       s.velocity = '0;
        1:       s.velocity = $signed(32'($urandom_range(7))) - 32'sd3;
        2:       ;
        default: begin
          s.velocity = 32'($urandom_range(32'h1F_FFFF, 32'h8000));
          if ($urandom_range(1)) s.velocity = -s.velocity;
        end
      endcase
      s.yaw_meas   = $signed(16'($urandom_range(4095))) - 16'sd2048;
      s.yaw_targ   = s.yaw_meas + $signed(16'($urandom_range(2047))) - 16'sd1024;
      s.pitch_meas = $signed(16'($urandom_range(4095))) - 16'sd2048;
      s.pitch_targ = s.pitch_meas + $signed(16'($urandom_range(2047))) - 16'sd1024;
      if ($urandom_range(3) != 0) begin
        s.yaw_rate   = $signed(20'($urandom_range(16383))) - 20'sd8192;
        s.pitch_rate = $signed(20'($urandom_range(16383))) - 20'sd8192;
      end
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    velocity_i       <= '0;
    yaw_measured_i   <= '0;
    yaw_target_i     <= '0;
    yaw_rate_i       <= '0;
    pitch_measured_i <= '0;
    pitch_target_i   <= '0;
    pitch_rate_i     <= '0;
    thrust_in_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (8) @(posedge clk_i);

    // directed words on reset defaults
    // zero speed with full thrust, thrust still passes through
    send_sample(make_sample(0, 16'sh7FFF, -16'sh8000, 20'sh7FFFF, 0, 16'sd100,
                            -20'sh80000, 32'hFFFF_FFFF));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
    // zero numerator: equal angles, no rate
    send_sample(make_sample(32'sh10000, 16'sd300, 16'sd300, 0, -16'sd5, -16'sd5, 0,
                            32'h1234_5678));
    // slowest speed magnitude: lookahead time saturates
    send_sample(make_sample(32'sd1, 0, 16'sd10, 20'sd1, 0, -16'sd10, -20'sd1, 32'd1));
    send_sample(make_sample(-32'sd1, 0, 16'sd10, 20'sh7FFFF, 0, -16'sd10,
                            -20'sh80000, 32'd2));
    // speed extremes with angle extremes
    send_sample(make_sample(32'sh7FFF_FFFF, -16'sh8000, 16'sh7FFF, 0,
                            16'sh7FFF, -16'sh8000, 0, 32'h8000_0000));
    send_sample(make_sample(-32'sh8000_0000, 16'sh7FFF, -16'sh8000, 20'sh7FFFF,
                            -16'sh8000, 16'sh7FFF, -20'sh80000, 32'h0000_FFFF));
    // large speed, small error: the asin argument still saturates on reset defaults
    send_sample(make_sample(32'sh0100_0000, 0, 16'sd40, 0, 0, -16'sd40, 0, 32'd7));
    send_sample(make_sample(-32'sh0040_0000, 16'sd20, 0, 20'sd100, 0, 16'sd3,
                            -20'sd100, 32'd8));
    drain();

    // physical setting, then directed words around the asin range
    load_regs(32'h1_0000, 32'h32_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'd715);
    send_sample(make_sample(32'sh5_0000, 0, 16'sd400, 0, 0, -16'sd400, 0, 32'd9));
    send_sample(make_sample(32'sh5_0000, 0, 16'sd2047, 20'sd4096, 0, -16'sd2047,
                            -20'sd4096, 32'd10));
    send_sample(make_sample(-32'sh2_0000, 16'sd1000, -16'sd1000, 20'sd2000,
                            -16'sd800, 16'sd800, 20'sd3000, 32'd11));
    send_sample(make_sample(32'sh1E_0000, 0, 16'sd4000, 0, 0, -16'sd4000, 0, 32'd12));
    drain();

    // no thrust: zero denominator with and without a numerator
    load_regs(32'h1_0000, 32'd0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'd6434);
    send_sample(make_sample(32'sh1_0000, 0, 16'sd100, 0, 0, 0, 0, 32'd13));
    send_sample(make_sample(-32'sh3_0000, 0, -16'sd100, 0, 16'sd5, 16'sd5, 0, 32'd14));
    drain();

    // random phases over register settings and idle patterns
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: load_regs(32'h1_0000, 32'h32_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                     32'd715);
        1: load_regs(0, 0, 0, 0, 0, 0);
        2: load_regs('1, '1, '1, '1, '1, '1);
        3: load_regs(32'($urandom_range(32'h4_0000, 32'h8000)),
                     32'($urandom_range(32'h100_0000, 32'h4_0000)),
                     32'($urandom_range(32'h2_0000, 32'h4000)),
                     32'($urandom_range(32'h4_0000)),
                     32'($urandom_range(32'h4_0000, 32'h4000)),
                     32'($urandom_range(6434)));
        4: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        5: load_regs(32'h2_0000, 32'h10_0000, 32'h8000, 32'h1_8000, 32'h2_0000,
                     32'd6434);
        default: load_regs(32'h1_0000, 32'h64_0000, 32'h1_0000, 32'h2_0000,
                           32'h4_0000, 32'($urandom_range(6434, 1)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_sample(rand_sample());
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/ftva_pkg.sv
design/ftva_axis.sv
design/feedforward_thrust_vector_angle_core.sv
bench/feedforward_thrust_vector_angle_core_tb.sv
